// ----- src/ssb_pkg.sv -----
// Package for the seven-segment scan blinker: constants, codes, and beat types.
// Used by every module of the block. No dependencies.
`default_nettype none

package ssb_pkg;

    // Display geometry.
    localparam int DIGIT_COUNT = 8;
    localparam int DIGIT_W     = 3;
    localparam int SEG_W       = 8;
    localparam int CNT_W       = 16;
    localparam int PERIOD_W    = 14;
    localparam int FLASH_W     = 8;
    localparam int DIV_W       = 8;

    // Command queue between the front and the back (depth is a power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Input opcodes.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BLANK = 2'd2
    } ssb_op_t;

    // Digit modes.
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_SLOW = 2'd2,
        MODE_FAST = 2'd3
    } ssb_mode_t;

    // Commands handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_SCAN  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_BLANK = 2'd2
    } ssb_cmd_kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLINK_PERIOD = 2'd0,
        CFG_SCAN_DIVIDER = 2'd1,
        CFG_FOREVER_CODE = 2'd2
    } ssb_cfg_idx_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ALIGN = 2'd1,
        ST_BLANK = 2'd2
    } ssb_state_t;

    // Input beat.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [DIGIT_W-1:0] digit;
        logic [SEG_W-1:0]   segment_bits;
        logic [1:0]         digit_mode;
        logic [FLASH_W-1:0] flash_count;
    } ssb_in_t;

    // Result beat.
    typedef struct packed {
        logic [SEG_W-1:0] digit_select;
        logic [SEG_W-1:0] segment_out;
        logic             last_word;
    } ssb_out_t;

    // Queue entry.
    typedef struct packed {
        ssb_cmd_kind_t      kind;
        logic [DIGIT_W-1:0] digit;
        logic [SEG_W-1:0]   segs;
        logic [1:0]         mode;
        logic [FLASH_W-1:0] flash;
    } ssb_cmd_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [PERIOD_W-1:0] blink_period;
        logic [FLASH_W-1:0]  forever_count_code;
    } ssb_cfg_t;

endpackage

`default_nettype wire

// ----- src/ssb_front.sv -----
// Front end of the scan blinker: accepts input beats, runs the tick prescaler
// and turns each beat into a queued command. Depends on ssb_pkg.
`default_nettype none

module ssb_front import ssb_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ssb_in_t          s_data,
    input  wire logic [DIV_W-1:0] scan_divider,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output ssb_cmd_t              push_cmd
);

    logic [DIV_W-1:0] div_count_reg, div_count_next;
    logic [DIV_W-1:0] div_inc;
    logic             accept;

    // A beat is taken whenever the queue has room, so every push succeeds.
    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Classify the beat and update the prescaler.
    always_comb begin
        div_inc        = div_count_reg + DIV_W'(1);
        div_count_next = div_count_reg;
        push_valid     = 1'b0;
        push_cmd.kind  = CMD_SCAN;
        push_cmd.digit = s_data.digit;
        push_cmd.segs  = s_data.segment_bits;
        push_cmd.mode  = s_data.digit_mode;
        push_cmd.flash = s_data.flash_count;
        case (s_data.opcode)
            OP_TICK: begin
                if (div_inc < scan_divider) begin
                    div_count_next = div_inc;
                end else begin
                    div_count_next = '0;
                    push_valid     = accept;
                end
            end
            OP_WRITE: begin
                push_cmd.kind = CMD_WRITE;
                push_valid    = accept;
            end
            OP_BLANK: begin
                push_cmd.kind  = CMD_BLANK;
                div_count_next = '0;
                push_valid     = accept;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            div_count_next = div_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_count_reg <= '0;
        end else begin
            div_count_reg <= div_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ssb_queue.sv -----
// Short command queue that decouples the front end from the back end.
// Depends on ssb_pkg for the entry type and depth.
`default_nettype none

module ssb_queue import ssb_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ssb_cmd_t in_cmd,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ssb_cmd_t      out_cmd
);

    ssb_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    // Pointers wrap naturally because the depth is a power of two.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/ssb_back.sv -----
// Back end of the scan blinker: per-digit state, the scan step, counter
// alignment, the blanking sequence and the output register. Depends on ssb_pkg.
`default_nettype none

module ssb_back import ssb_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire ssb_cfg_t cfg,
    input  wire logic     q_valid,
    output logic          q_ready,
    input  wire ssb_cmd_t q_cmd,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ssb_out_t      m_data
);

    localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGIT_COUNT - 1);

    // Per-digit state.
    logic [SEG_W-1:0]       seg_reg     [DIGIT_COUNT];
    ssb_mode_t              mode_reg    [DIGIT_COUNT];
    logic [FLASH_W-1:0]     flash_reg   [DIGIT_COUNT];
    logic [CNT_W-1:0]       counter_reg [DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0] fast_mark_reg, fast_mark_next;
    logic [DIGIT_COUNT-1:0] slow_mark_reg, slow_mark_next;

    // Sequencer.
    ssb_state_t         state_reg, state_next;
    logic [DIGIT_W-1:0] pos_reg, pos_next;
    logic [DIGIT_W-1:0] idx_reg, idx_next;
    logic               slow_ok_reg, slow_ok_next;
    logic               fast_ok_reg, fast_ok_next;
    logic [CNT_W-1:0]   slow_ref_reg, slow_ref_next;
    logic [CNT_W-1:0]   fast_ref_reg, fast_ref_next;

    // Output register.
    logic     out_valid_reg, out_valid_next;
    ssb_out_t out_data_reg;
    ssb_out_t out_word;
    logic     out_load;
    logic     out_free;

    // Digit state write port.
    logic [DIGIT_W-1:0] wr_addr;
    logic               seg_we, mode_we, flash_we, cnt_we;
    logic [SEG_W-1:0]   seg_wdata;
    ssb_mode_t          mode_wdata;
    logic [FLASH_W-1:0] flash_wdata;
    logic [CNT_W-1:0]   cnt_wdata;

    // Digit state read port.
    logic [DIGIT_W-1:0] rd_addr;
    logic [SEG_W-1:0]   cur_seg;
    ssb_mode_t          cur_mode;
    logic [FLASH_W-1:0] cur_flash;
    logic [CNT_W-1:0]   cur_cnt;

    // Scan step datapath.
    logic [CNT_W-1:0]   period;
    logic [CNT_W-1:0]   thr;
    logic [CNT_W-1:0]   cnt_load;
    logic [CNT_W-1:0]   cnt_dec;
    logic [FLASH_W-1:0] step_flash;
    ssb_mode_t          step_mode;
    logic [SEG_W-1:0]   step_seg;

    // Alignment datapath.
    logic [CNT_W-1:0] al_cnt;

    function automatic logic [SEG_W-1:0] select_byte(input logic [DIGIT_W-1:0] d);
        return ~(SEG_W'(1) << d);
    endfunction

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // One read address: the alignment sweep during ST_ALIGN, else the scan position.
    assign rd_addr   = (state_reg == ST_ALIGN) ? idx_reg : pos_reg;
    assign cur_seg   = seg_reg[rd_addr];
    assign cur_mode  = mode_reg[rd_addr];
    assign cur_flash = flash_reg[rd_addr];
    assign cur_cnt   = counter_reg[rd_addr];

    // Scan step: period, flash countdown, threshold and counter update.
    always_comb begin
        period     = CNT_W'(cfg.blink_period);
        step_flash = cur_flash;
        step_mode  = cur_mode;
        case (cur_mode)
            MODE_FAST: begin
                period = CNT_W'(cfg.blink_period >> 1);
                if (cur_flash != '0 && cur_flash != cfg.forever_count_code) begin
                    step_flash = cur_flash - FLASH_W'(1);
                end
                if (step_flash == '0) begin
                    step_mode = MODE_ON;
                end
            end
            MODE_SLOW: begin
                period = {CNT_W'(cfg.blink_period)} << 1;
            end
            default: begin
            end
        endcase
        case (step_mode)
            MODE_ON:   thr = period;
            MODE_SLOW: thr = period >> 1;
            MODE_FAST: thr = period >> 1;
            default:   thr = '0;
        endcase
        cnt_load = (cur_cnt == '0) ? period : cur_cnt;
        cnt_dec  = cnt_load - CNT_W'(1);
        step_seg = (cnt_dec >= thr) ? '0 : cur_seg;
    end

    // Alignment: the first marked digit of each speed is the reference.
    always_comb begin
        al_cnt        = cur_cnt;
        slow_ok_next  = slow_ok_reg;
        fast_ok_next  = fast_ok_reg;
        slow_ref_next = slow_ref_reg;
        fast_ref_next = fast_ref_reg;
        if (state_reg == ST_ALIGN) begin
            if (slow_mark_reg[idx_reg]) begin
                if (slow_ok_reg) begin
                    al_cnt = slow_ref_reg;
                end else begin
                    slow_ref_next = cur_cnt;
                    slow_ok_next  = 1'b1;
                end
            end
            if (fast_mark_reg[idx_reg]) begin
                if (fast_ok_reg) begin
                    al_cnt = fast_ref_reg;
                end else begin
                    fast_ref_next = al_cnt;
                    fast_ok_next  = 1'b1;
                end
            end
        end else begin
            slow_ok_next = 1'b0;
            fast_ok_next = 1'b0;
        end
    end

    // Sequencer: next state, queue pop, digit writes and output beats.
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        fast_mark_next = fast_mark_reg;
        slow_mark_next = slow_mark_reg;
        q_ready        = 1'b0;
        out_load       = 1'b0;
        out_word       = '{digit_select: select_byte(idx_reg), segment_out: '0,
                           last_word: (idx_reg == LAST_DIGIT)};
        wr_addr        = pos_reg;
        seg_we         = 1'b0;
        mode_we        = 1'b0;
        flash_we       = 1'b0;
        cnt_we         = 1'b0;
        seg_wdata      = q_cmd.segs;
        mode_wdata     = step_mode;
        flash_wdata    = step_flash;
        cnt_wdata      = cnt_dec;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.kind)
                        CMD_WRITE: begin
                            q_ready     = 1'b1;
                            wr_addr     = q_cmd.digit;
                            seg_we      = (int'(q_cmd.digit) < DIGIT_COUNT);
                            mode_we     = seg_we;
                            flash_we    = seg_we;
                            mode_wdata  = ssb_mode_t'(q_cmd.mode);
                            flash_wdata = q_cmd.flash;
                        end
                        CMD_SCAN: begin
                            if (out_free) begin
                                q_ready  = 1'b1;
                                out_load = 1'b1;
                                out_word = '{digit_select: select_byte(pos_reg),
                                             segment_out: step_seg, last_word: 1'b1};
                                mode_we  = 1'b1;
                                flash_we = 1'b1;
                                cnt_we   = 1'b1;
                                fast_mark_next[pos_reg] = (cur_mode == MODE_FAST);
                                slow_mark_next[pos_reg] = (cur_mode == MODE_SLOW);
                                if (pos_reg == LAST_DIGIT) begin
                                    pos_next   = '0;
                                    idx_next   = '0;
                                    state_next = ST_ALIGN;
                                end else begin
                                    pos_next = pos_reg + DIGIT_W'(1);
                                end
                            end
                        end
                        CMD_BLANK: begin
                            q_ready        = 1'b1;
                            fast_mark_next = '0;
                            slow_mark_next = '0;
                            pos_next       = '0;
                            idx_next       = '0;
                            state_next     = ST_BLANK;
                        end
                        default: begin
                            q_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALIGN: begin
                wr_addr   = idx_reg;
                cnt_we    = 1'b1;
                cnt_wdata = al_cnt;
                idx_next  = idx_reg + DIGIT_W'(1);
                if (idx_reg == LAST_DIGIT) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_BLANK: begin
                if (out_free) begin
                    out_load = 1'b1;
                    idx_next = idx_reg + DIGIT_W'(1);
                    if (idx_reg == LAST_DIGIT) begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new beat, cleared when the beat is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            idx_reg       <= '0;
            slow_ok_reg   <= 1'b0;
            fast_ok_reg   <= 1'b0;
            fast_mark_reg <= '0;
            slow_mark_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            slow_ok_reg   <= slow_ok_next;
            fast_ok_reg   <= fast_ok_next;
            fast_mark_reg <= fast_mark_next;
            slow_mark_reg <= slow_mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        slow_ref_reg <= slow_ref_next;
        fast_ref_reg <= fast_ref_next;
        if (out_load) begin
            out_data_reg <= out_word;
        end
    end

    // Digit state, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                seg_reg[k]     <= '0;
                mode_reg[k]    <= MODE_OFF;
                flash_reg[k]   <= '0;
                counter_reg[k] <= '0;
            end
        end else begin
            if (seg_we) begin
                seg_reg[wr_addr] <= seg_wdata;
            end
            if (mode_we) begin
                mode_reg[wr_addr] <= mode_wdata;
            end
            if (flash_we) begin
                flash_reg[wr_addr] <= flash_wdata;
            end
            if (cnt_we) begin
                counter_reg[wr_addr] <= cnt_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/seven_segment_scan_blinker_top.sv -----
// Top level of the seven-segment scan blinker: configuration registers and
// the front end, command queue and back end. Depends on ssb_pkg, ssb_front,
// ssb_queue and ssb_back.
//
// Drives eight multiplexed seven-segment digits, one result beat per scan
// step. Every input beat is taken while the two-entry command queue has
// room. In the back end, after the eighth digit of a scan the counter
// alignment sweeps the digits one per cycle, and a blank op sends its eight
// words in turn, each when the output register is free. The per-digit state
// is shared by the scan step and the alignment sweep. Result beats sit in
// an output register, so the front end keeps taking beats while a result
// waits, until the command queue is full.
`default_nettype none

module seven_segment_scan_blinker_top import ssb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ssb_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output ssb_out_t                   m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PERIOD_W-1:0] blink_period_reg, blink_period_next;
    logic [DIV_W-1:0]    scan_divider_reg, scan_divider_next;
    logic [FLASH_W-1:0]  forever_code_reg, forever_code_next;
    ssb_cfg_t            back_cfg;

    logic     push_valid, push_ready;
    ssb_cmd_t push_cmd;
    logic     pop_valid, pop_ready;
    ssb_cmd_t pop_cmd;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        blink_period_next = blink_period_reg;
        scan_divider_next = scan_divider_reg;
        forever_code_next = forever_code_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_BLINK_PERIOD: blink_period_next = cfg_data[PERIOD_W-1:0];
                CFG_SCAN_DIVIDER: scan_divider_next = cfg_data[DIV_W-1:0];
                CFG_FOREVER_CODE: forever_code_next = cfg_data[FLASH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg <= PERIOD_W'(100);
            scan_divider_reg <= DIV_W'(6);
            forever_code_reg <= FLASH_W'(255);
        end else begin
            blink_period_reg <= blink_period_next;
            scan_divider_reg <= scan_divider_next;
            forever_code_reg <= forever_code_next;
        end
    end

    assign back_cfg.blink_period       = blink_period_reg;
    assign back_cfg.forever_count_code = forever_code_reg;

    ssb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .scan_divider (scan_divider_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    ssb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_cmd   (pop_cmd)
    );

    ssb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (back_cfg),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_cmd   (pop_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the seven-segment scan blinker top level.
// Depends on ssb_pkg and seven_segment_scan_blinker_top; it predicts every display
// word from its own model of the digit store, the blink counters and the scan.

module tb;
    import ssb_pkg::*;

    localparam int  CLK_HALF_NS  = 4;
    localparam int  RESET_CYCLES = 10;
    localparam int  SETTLE_CYCLES = 32;
    localparam int  DRAIN_LIMIT  = 20000;
    localparam int  WATCHDOG_NS  = 4_000_000;
    localparam int  HOLD_CYCLES  = 400;

    // Codes the package leaves unnamed.
    localparam logic [1:0]           OP_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    ssb_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    ssb_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted display state and register copies.
    logic [SEG_W-1:0]    seg_store  [DIGIT_COUNT];
    ssb_mode_t           mode_store [DIGIT_COUNT];
    logic [FLASH_W-1:0]  flash_left [DIGIT_COUNT];
    logic [CNT_W-1:0]    blink_cnt  [DIGIT_COUNT];
    logic                fast_mark  [DIGIT_COUNT];
    logic                slow_mark  [DIGIT_COUNT];
    logic [DIGIT_W-1:0]  scan_pos;
    logic [DIV_W-1:0]    div_count;
    logic [PERIOD_W-1:0] reg_period;
    logic [DIV_W-1:0]    reg_divider;
    logic [FLASH_W-1:0]  reg_forever;

    ssb_out_t pending_words[$];

    int send_idle_pct     = 0;
    int sink_stall_pct    = 0;
    int sink_hold_cycles  = 0;
    int error_count       = 0;
    int cmds_sent         = 0;
    int words_checked     = 0;
    int reg_writes        = 0;

    seven_segment_scan_blinker_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // Works out the display words that one accepted command produces.
    function automatic void predict_display_words(input ssb_in_t cmd);
        ssb_out_t           word;
        logic [DIGIT_W-1:0] idx;
        logic [CNT_W-1:0]   period;
        logic [CNT_W-1:0]   thr;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   slow_ref;
        logic [CNT_W-1:0]   fast_ref;
        logic               slow_seen;
        logic               fast_seen;
        case (cmd.opcode)
            OP_TICK: begin
                div_count = div_count + 1'b1;
                if (div_count >= reg_divider) begin
                    div_count = '0;
                    idx = scan_pos;
                    fast_mark[idx] = 1'b0;
                    slow_mark[idx] = 1'b0;
                    period = {{(CNT_W-PERIOD_W){1'b0}}, reg_period};
                    if (mode_store[idx] == MODE_FAST) begin
                        period = period >> 1;
                        fast_mark[idx] = 1'b1;
                        if (flash_left[idx] != '0 && flash_left[idx] != reg_forever)
                            flash_left[idx] = flash_left[idx] - 1'b1;
                        // Countdown done: the digit falls back to steady on.
                        if (flash_left[idx] == '0)
                            mode_store[idx] = MODE_ON;
                    end else if (mode_store[idx] == MODE_SLOW) begin
                        period = period << 1;
                        slow_mark[idx] = 1'b1;
                    end
                    case (mode_store[idx])
                        MODE_ON:              thr = period;
                        MODE_SLOW, MODE_FAST: thr = period >> 1;
                        default:              thr = '0;
                    endcase
                    cnt = blink_cnt[idx];
                    if (cnt == '0)
                        cnt = period;
                    cnt = cnt - 1'b1;
                    blink_cnt[idx] = cnt;
                    word.digit_select = ~(8'd1 << idx);
                    word.segment_out  = (cnt >= thr) ? '0 : seg_store[idx];
                    word.last_word    = 1'b1;
                    pending_words.push_back(word);
                    // After the last digit, line up the counters of each blink speed.
                    if (idx == DIGIT_W'(DIGIT_COUNT - 1)) begin
                        slow_seen = 1'b0;
                        fast_seen = 1'b0;
                        slow_ref  = '0;
                        fast_ref  = '0;
                        for (int j = 0; j < DIGIT_COUNT; j++) begin
                            if (slow_mark[j]) begin
                                if (slow_seen) begin
                                    blink_cnt[j] = slow_ref;
                                end else begin
                                    slow_ref  = blink_cnt[j];
                                    slow_seen = 1'b1;
                                end
                            end
                            if (fast_mark[j]) begin
                                if (fast_seen) begin
                                    blink_cnt[j] = fast_ref;
                                end else begin
                                    fast_ref  = blink_cnt[j];
                                    fast_seen = 1'b1;
                                end
                            end
                        end
                    end
                    scan_pos = idx + 1'b1;
                end
            end
            OP_WRITE: begin
                seg_store[cmd.digit]  = cmd.segment_bits;
                mode_store[cmd.digit] = ssb_mode_t'(cmd.digit_mode);
                flash_left[cmd.digit] = cmd.flash_count;
            end
            OP_BLANK: begin
                for (int j = 0; j < DIGIT_COUNT; j++) begin
                    word.digit_select = ~(8'd1 << j);
                    word.segment_out  = '0;
                    word.last_word    = (j == DIGIT_COUNT - 1);
                    pending_words.push_back(word);
                    fast_mark[j] = 1'b0;
                    slow_mark[j] = 1'b0;
                end
                scan_pos  = '0;
                div_count = '0;
            end
            default: begin
            end
        endcase
    endfunction

    // Offers one command beat, with a random gap first, and waits for it to be taken.
    task automatic offer_display_cmd(input ssb_in_t cmd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_display_words(cmd);
        cmds_sent++;
    endtask

    function automatic ssb_in_t tick_cmd();
        ssb_in_t cmd;
        cmd        = ssb_in_t'($urandom);
        cmd.opcode = OP_TICK;
        return cmd;
    endfunction

    function automatic ssb_in_t blank_cmd();
        ssb_in_t cmd;
        cmd        = ssb_in_t'($urandom);
        cmd.opcode = OP_BLANK;
        return cmd;
    endfunction

    function automatic ssb_in_t write_cmd(input logic [DIGIT_W-1:0] digit,
                                          input logic [SEG_W-1:0] segs,
                                          input ssb_mode_t mode,
                                          input logic [FLASH_W-1:0] flash);
        ssb_in_t cmd;
        cmd.opcode       = OP_WRITE;
        cmd.digit        = digit;
        cmd.segment_bits = segs;
        cmd.digit_mode   = mode;
        cmd.flash_count  = flash;
        return cmd;
    endfunction

    task automatic send_ticks(input int count);
        repeat (count) offer_display_cmd(tick_cmd());
    endtask

    // Stops offering, waits for every predicted word, then lets the back end settle.
    task automatic wait_display_idle();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_words.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_words.size() != 0) begin
            $display("%0t: %0d predicted display words never arrived",
                     $realtime, pending_words.size());
            error_count++;
            pending_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register on the configuration channel while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_display_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BLINK_PERIOD: reg_period  = value[PERIOD_W-1:0];
            CFG_SCAN_DIVIDER: reg_divider = value[DIV_W-1:0];
            CFG_FOREVER_CODE: reg_forever = value[FLASH_W-1:0];
            default: begin
            end
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    // Eight-bit registers get random upper data bits, which must be dropped.
    task automatic set_registers(input int period, input int divider, input int forever_code);
        write_register(CFG_BLINK_PERIOD, CFG_DATA_W'(period));
        write_register(CFG_SCAN_DIVIDER, {6'($urandom), 8'(divider)});
        write_register(CFG_FOREVER_CODE, {6'($urandom), 8'(forever_code)});
    endtask

    // Result side: random or held-off ready, and a check of every accepted beat.
    initial begin
        ssb_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected display word, actual %h", $realtime, m_data);
                    error_count++;
                end else begin
                    want = pending_words.pop_front();
                    words_checked++;
                    if (m_data.digit_select !== want.digit_select) begin
                        $display("%0t: digit_select expected %h actual %h",
                                 $realtime, want.digit_select, m_data.digit_select);
                        error_count++;
                    end
                    if (m_data.segment_out !== want.segment_out) begin
                        $display("%0t: segment_out expected %h actual %h",
                                 $realtime, want.segment_out, m_data.segment_out);
                        error_count++;
                    end
                    if (m_data.last_word !== want.last_word) begin
                        $display("%0t: last_word expected %b actual %b",
                                 $realtime, want.last_word, m_data.last_word);
                        error_count++;
                    end
                end
            end
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Reset register values: six ticks per step, a steady-on digit, an unused opcode
    // and a blank.
    task automatic test_reset_values();
        ssb_in_t cmd;
        send_ticks(6);
        offer_display_cmd(write_cmd(3'd1, 8'h5a, MODE_ON, 8'd0));
        send_ticks(6);
        cmd        = ssb_in_t'($urandom);
        cmd.opcode = OP_UNUSED;
        offer_display_cmd(cmd);
        offer_display_cmd(blank_cmd());
        send_ticks(6);
    endtask

    // One digit in each mode, fast digits counting down, forever and starting at zero.
    task automatic test_digit_modes();
        set_registers(6, 1, 255);
        offer_display_cmd(write_cmd(3'd0, 8'hff, MODE_OFF,  8'd0));
        offer_display_cmd(write_cmd(3'd1, 8'h7f, MODE_ON,   8'd9));
        offer_display_cmd(write_cmd(3'd2, 8'hff, MODE_SLOW, 8'd0));
        offer_display_cmd(write_cmd(3'd3, 8'h3c, MODE_FAST, 8'd2));
        offer_display_cmd(write_cmd(3'd4, 8'hc3, MODE_FAST, 8'd255));
        offer_display_cmd(write_cmd(3'd5, 8'h00, MODE_FAST, 8'd0));
        offer_display_cmd(write_cmd(3'd6, 8'h80, MODE_ON,   8'd1));
        offer_display_cmd(write_cmd(3'd7, 8'h01, MODE_SLOW, 8'd77));
        send_ticks(24);
    endtask

    // Largest period and divider, a zero forever code, the shortest periods, where a
    // fast digit gets a zero period, and a write to the spare register index.
    task automatic test_register_extremes();
        set_registers(16383, 255, 0);
        offer_display_cmd(write_cmd(3'd0, 8'hf0, MODE_FAST, 8'd3));
        send_ticks(60);
        write_register(CFG_SCAN_DIVIDER, CFG_DATA_W'(1));
        send_ticks(16);
        write_register(CFG_BLINK_PERIOD, CFG_DATA_W'(2));
        offer_display_cmd(write_cmd(3'd2, 8'h0f, MODE_FAST, 8'd0));
        send_ticks(8);
        write_register(CFG_BLINK_PERIOD, CFG_DATA_W'(1));
        offer_display_cmd(write_cmd(3'd3, 8'hee, MODE_FAST, 8'd255));
        send_ticks(16);
        write_register(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
        send_ticks(8);
    endtask

    // Output held off for a long stretch while ticks keep coming, then a full drain.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        set_registers(5, 1, 255);
        offer_display_cmd(write_cmd(3'd1, 8'h6d, MODE_SLOW, 8'd0));
        offer_display_cmd(write_cmd(3'd4, 8'h5b, MODE_FAST, 8'd4));
        sink_hold_cycles = HOLD_CYCLES;
        send_ticks(40);
        offer_display_cmd(blank_cmd());
        send_ticks(10);
        wait_display_idle();
        send_ticks(12);
    endtask

    // Random commands, mostly ticks and digit writes with short fast countdowns.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int period, input int divider,
                                       input int forever_code, input int count);
        ssb_in_t            cmd;
        logic [FLASH_W-1:0] flash;
        int                 pick;
        int                 done;
        set_registers(period, divider, forever_code);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 58) begin
                cmd = tick_cmd();
            end else if (pick < 88) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: flash = FLASH_W'($urandom_range(6, 1));
                    4, 5:       flash = reg_forever;
                    6:          flash = '0;
                    default:    flash = FLASH_W'($urandom);
                endcase
                cmd = write_cmd(DIGIT_W'($urandom), SEG_W'($urandom),
                                ssb_mode_t'($urandom_range(3)), flash);
            end else if (pick < 96) begin
                cmd = blank_cmd();
            end else begin
                cmd        = ssb_in_t'($urandom);
                cmd.opcode = OP_UNUSED;
            end
            offer_display_cmd(cmd);
            if (cmd.opcode != OP_UNUSED)
                done++;
        end
    endtask

    initial begin
        for (int j = 0; j < DIGIT_COUNT; j++) begin
            seg_store[j]  = '0;
            mode_store[j] = MODE_OFF;
            flash_left[j] = '0;
            blink_cnt[j]  = '0;
            fast_mark[j]  = 1'b0;
            slow_mark[j]  = 1'b0;
        end
        scan_pos    = '0;
        div_count   = '0;
        reg_period  = PERIOD_W'(100);
        reg_divider = DIV_W'(6);
        reg_forever = FLASH_W'(255);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_digit_modes();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic(0,  0,  4,  1, 255, 45);
        test_random_traffic(71, 0,  7,  2, 3,   45);
        test_random_traffic(0,  71, 2,  1, 0,   45);
        test_random_traffic(25, 25, 10, 3, $urandom_range(255), 45);

        wait_display_idle();
        $display("Sent %0d commands and checked %0d display words over %0d register writes,",
                 cmds_sent, words_checked, reg_writes);
        $display("covering all digit modes, blanking, a long output stall and four idle mixes.");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(WATCHDOG_NS);
        $display("%0t: watchdog expired", $realtime);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
src/ssb_pkg.sv
src/ssb_front.sv
src/ssb_queue.sv
src/ssb_back.sv
src/seven_segment_scan_blinker_top.sv
tb/sv/tb.sv
